/* rtl/assert_macros.svh */
// Assertion macros for the RTL of the PD controller.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Checks that a property holds at every clock edge outside reset.
`define PDC_ASSERT(lbl, prop, msg) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (prop)) else $error(msg);

// Checks that a condition never occurs outside reset.
`define PDC_NEVER(lbl, cond, msg) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) !(cond)) else $error(msg);

`endif

/* rtl/pdc_pkg.sv */
// Package with the types, widths and codes of the PD controller.
package pdc_pkg;

    localparam int GAIN_W  = 16;
    localparam int VAL_W   = 16;
    localparam int ERR_W   = VAL_W + 1;
    localparam int DERR_W  = ERR_W + 1;
    localparam int TIME_W  = 32;
    localparam int DRIVE_W = 32;
    localparam int PROD_W  = GAIN_W + DERR_W;
    localparam int ACC_W   = GAIN_W + ERR_W;
    localparam int FRAC_W  = 8;
    localparam int CNT_W   = $clog2(TIME_W);
    localparam int IDX_W   = 1;

    typedef logic signed [GAIN_W-1:0]  gain_t;
    typedef logic signed [VAL_W-1:0]   value_t;
    typedef logic signed [ERR_W-1:0]   error_t;
    typedef logic        [TIME_W-1:0]  stamp_t;
    typedef logic signed [DRIVE_W-1:0] drive_t;
    typedef logic        [IDX_W-1:0]   reg_idx_t;

    localparam reg_idx_t REG_PROP_GAIN  = 1'b0;
    localparam reg_idx_t REG_DERIV_GAIN = 1'b1;

    localparam gain_t PROP_GAIN_RESET  = 16'sd256;
    localparam gain_t DERIV_GAIN_RESET = 16'sd0;

    typedef enum logic [2:0] {
        S_IDLE,
        S_PMUL,
        S_DMUL,
        S_DIV,
        S_DONE
    } state_t;

    typedef struct packed {
        logic cmd_ready;
        logic sel_deriv;
        logic mul_prop;
        logic mul_deriv;
        logic div_step;
        logic finish;
    } ctrl_t;

endpackage

/* rtl/pdc_cmd_if.sv */
// Valid/ready channel interfaces for the controller command and response items.
interface pdc_cmd_if;
    import pdc_pkg::*;

    logic   valid;
    logic   ready;
    logic   func;
    value_t setpoint;
    value_t measured;
    stamp_t timestamp;

    modport source (output valid, output func, output setpoint, output measured,
                    output timestamp, input ready);
    modport sink (input valid, input func, input setpoint, input measured,
                  input timestamp, output ready);
endinterface

interface pdc_rsp_if;
    import pdc_pkg::*;

    logic   valid;
    logic   ready;
    drive_t drive;
    logic   status;

    modport source (output valid, output drive, output status, input ready);
    modport sink (input valid, input drive, input status, output ready);
endinterface

/* rtl/pd_controller_step.sv */
// Top level of the PD controller: sequencer, shared multiplier and serial divider.
//
// One command item is taken at a time. A proportional-only item, or a PD item
// whose time step is zero, passes from S_PMUL straight to S_DONE; a PD item goes
// through S_PMUL, S_DMUL, S_DIV and S_DONE, using the one shared 16 x 18 bit
// multiplier twice and a radix-2 divider that retires one quotient bit per cycle.
// The block takes the next command once the response has moved into the
// output register, which holds it until the sink takes it.
`include "assert_macros.svh"

module pd_controller_step (
    input  logic              clk,
    input  logic              rst_n,
    input  logic              cfg_we,
    input  pdc_pkg::reg_idx_t cfg_idx,
    input  pdc_pkg::gain_t    cfg_wdata,
    pdc_cmd_if.sink           cmd,
    pdc_rsp_if.source         rsp
);
    import pdc_pkg::*;

    state_t state_reg, state_next;
    ctrl_t  ctrl;

    gain_t  prop_gain_reg, deriv_gain_reg;
    error_t prev_error_reg;
    stamp_t prev_time_reg;
    drive_t held_drive_reg;

    logic   func_reg;
    error_t err_reg;
    stamp_t ts_reg;
    stamp_t dt_reg;
    logic signed [ACC_W-1:0] acc_reg;
    logic   neg_reg;
    logic [TIME_W-1:0] rem_reg, rem_next;
    logic [TIME_W-1:0] quo_reg, quo_next;
    logic [CNT_W-1:0]  cnt_reg;

    drive_t drive_reg;
    logic   status_reg;
    logic   out_valid_reg;

    logic                     out_free;
    logic                     hold;
    logic signed [DERR_W-1:0] derr;
    logic signed [GAIN_W-1:0] mul_a;
    logic signed [DERR_W-1:0] mul_b;
    logic signed [PROD_W-1:0] prod;
    logic        [PROD_W-1:0] mag;
    logic        [TIME_W+1:0] trial;
    logic signed [PROD_W-1:0] dterm;
    logic signed [PROD_W-1:0] sum;
    drive_t                   drive_calc;

    assign out_free = !out_valid_reg || rsp.ready;
    assign hold     = func_reg && (dt_reg == '0);

    // Shared multiplier: proportional term first, then the derivative product.
    assign derr  = DERR_W'(err_reg) - DERR_W'(prev_error_reg);
    assign mul_a = ctrl.sel_deriv ? deriv_gain_reg : prop_gain_reg;
    assign mul_b = ctrl.sel_deriv ? derr : DERR_W'(err_reg);
    assign prod  = PROD_W'(mul_a) * PROD_W'(mul_b);
    assign mag   = prod[PROD_W-1] ? PROD_W'(-prod) : PROD_W'(prod);

    // One restoring division step per cycle.
    assign trial = {1'b0, rem_reg, quo_reg[TIME_W-1]} - {2'b00, dt_reg};
    always_comb
    begin
        if (trial[TIME_W+1])
        begin
            rem_next = {rem_reg[TIME_W-2:0], quo_reg[TIME_W-1]};
        end
        else
        begin
            rem_next = trial[TIME_W-1:0];
        end
        quo_next = {quo_reg[TIME_W-2:0], ~trial[TIME_W+1]};
    end

    always_comb
    begin
        if (!func_reg || hold)
        begin
            dterm = '0;
        end
        else if (neg_reg)
        begin
            dterm = -$signed({2'b00, quo_reg});
        end
        else
        begin
            dterm = $signed({2'b00, quo_reg});
        end
    end

    // The shifted sum never leaves the 32-bit range, so no saturation is needed.
    assign sum        = PROD_W'(acc_reg) + dterm;
    assign drive_calc = DRIVE_W'($signed(sum[PROD_W-1:FRAC_W]));

    always_comb
    begin
        state_next = state_reg;
        case (state_reg)
            S_IDLE:
            begin
                if (cmd.valid)
                begin
                    state_next = S_PMUL;
                end
            end
            S_PMUL:
            begin
                if (!func_reg || hold)
                begin
                    state_next = S_DONE;
                end
                else
                begin
                    state_next = S_DMUL;
                end
            end
            S_DMUL:
            begin
                state_next = S_DIV;
            end
            S_DIV:
            begin
                if (cnt_reg == CNT_W'(TIME_W - 1))
                begin
                    state_next = S_DONE;
                end
            end
            S_DONE:
            begin
                if (out_free)
                begin
                    state_next = S_IDLE;
                end
            end
            default:
            begin
                state_next = S_IDLE;
            end
        endcase
    end

    always_comb
    begin
        ctrl = '0;
        case (state_reg)
            S_IDLE:
            begin
                ctrl.cmd_ready = 1'b1;
            end
            S_PMUL:
            begin
                ctrl.mul_prop = 1'b1;
            end
            S_DMUL:
            begin
                ctrl.sel_deriv = 1'b1;
                ctrl.mul_deriv = 1'b1;
            end
            S_DIV:
            begin
                ctrl.div_step = 1'b1;
            end
            S_DONE:
            begin
                ctrl.finish = out_free;
            end
            default:
            begin
                ctrl = '0;
            end
        endcase
    end

    assign cmd.ready  = ctrl.cmd_ready;
    assign rsp.valid  = out_valid_reg;
    assign rsp.drive  = drive_reg;
    assign rsp.status = status_reg;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg      <= S_IDLE;
            out_valid_reg  <= 1'b0;
            prop_gain_reg  <= PROP_GAIN_RESET;
            deriv_gain_reg <= DERIV_GAIN_RESET;
            prev_error_reg <= '0;
            prev_time_reg  <= '0;
            held_drive_reg <= '0;
            cnt_reg        <= '0;
        end
        else
        begin
            state_reg <= state_next;
            if (cfg_we)
            begin
                case (cfg_idx)
                    REG_PROP_GAIN:  prop_gain_reg  <= cfg_wdata;
                    REG_DERIV_GAIN: deriv_gain_reg <= cfg_wdata;
                    default:        prop_gain_reg  <= prop_gain_reg;
                endcase
            end
            if (ctrl.mul_deriv)
            begin
                cnt_reg <= '0;
            end
            else if (ctrl.div_step)
            begin
                cnt_reg <= cnt_reg + 1'b1;
            end
            if (ctrl.finish)
            begin
                out_valid_reg <= 1'b1;
                if (!hold)
                begin
                    prev_error_reg <= err_reg;
                    held_drive_reg <= drive_calc;
                    if (func_reg)
                    begin
                        prev_time_reg <= ts_reg;
                    end
                end
            end
            else if (rsp.ready)
            begin
                out_valid_reg <= 1'b0;
            end
        end
    end

    always_ff @(posedge clk)
    begin
        if (cmd.valid && ctrl.cmd_ready)
        begin
            func_reg <= cmd.func;
            err_reg  <= ERR_W'(cmd.setpoint) - ERR_W'(cmd.measured);
            ts_reg   <= cmd.timestamp;
            dt_reg   <= cmd.timestamp - prev_time_reg;
        end
        if (ctrl.mul_prop)
        begin
            acc_reg <= prod[ACC_W-1:0];
        end
        if (ctrl.mul_deriv)
        begin
            neg_reg <= prod[PROD_W-1];
            quo_reg <= mag[TIME_W-1:0];
            rem_reg <= '0;
        end
        else if (ctrl.div_step)
        begin
            quo_reg <= quo_next;
            rem_reg <= rem_next;
        end
        if (ctrl.finish)
        begin
            drive_reg  <= hold ? held_drive_reg : drive_calc;
            status_reg <= hold;
        end
    end

    `PDC_ASSERT(a_accept_starts, (cmd.valid && cmd.ready) |=> (state_reg == S_PMUL), "accepted item did not start")
    `PDC_ASSERT(a_div_runs, (state_reg == S_DIV && cnt_reg != CNT_W'(TIME_W - 1)) |=> (state_reg == S_DIV), "division ended early")
    `PDC_NEVER(a_rem_bound, (state_reg == S_DIV) && (rem_reg >= dt_reg), "division remainder not below time step")
    `PDC_ASSERT(a_held_status, (out_valid_reg && status_reg) |-> (drive_reg == held_drive_reg), "held response differs from stored drive")

endmodule

/* bench/tb_top.sv */
// Self-checking testbench of the PD controller step block with a built-in drive predictor.
module tb_top;
    import pdc_pkg::*;

    typedef struct packed {
        logic   func;
        value_t setpoint;
        value_t measured;
        stamp_t timestamp;
    } cmd_item_t;

    typedef struct packed {
        drive_t drive;
        logic   status;
    } drive_item_t;

    localparam longint DRIVE_MAX = 64'sd2147483647;
    localparam longint DRIVE_MIN = -64'sd2147483648;

    logic     clk;
    logic     rst_n;
    logic     cfg_we;
    reg_idx_t cfg_idx;
    gain_t    cfg_wdata;

    pdc_cmd_if cmd_ch ();
    pdc_rsp_if rsp_ch ();

    pd_controller_step dut (
        .clk       (clk),
        .rst_n     (rst_n),
        .cfg_we    (cfg_we),
        .cfg_idx   (cfg_idx),
        .cfg_wdata (cfg_wdata),
        .cmd       (cmd_ch),
        .rsp       (rsp_ch)
    );

    cmd_item_t   pending_cmds[$];
    drive_item_t expected_drives[$];

    gain_t  kp;
    gain_t  kd;
    error_t last_error;
    stamp_t last_stamp;
    drive_t last_drive;
    stamp_t gen_stamp;

    int send_idle_pct;
    int stall_pct;
    int items_queued;
    int results_seen;
    int mismatches;

    initial begin
        clk = 1'b0;
    end

    always #6 clk = ~clk;

    function automatic longint clamp_drive(longint v);
        if (v > DRIVE_MAX)
            return DRIVE_MAX;
        if (v < DRIVE_MIN)
            return DRIVE_MIN;
        return v;
    endfunction

    function automatic drive_item_t compute_drive(cmd_item_t c);
        longint      err;
        longint      acc;
        longint      prod;
        longint      dterm;
        logic [63:0] mag;
        logic [63:0] quot;
        stamp_t      dt;
        logic        neg;
        drive_item_t r;
        err = longint'(c.setpoint) - longint'(c.measured);
        acc = longint'(kp) * err;
        r.status = 1'b0;
        if (c.func == 1'b0) begin
            r.drive = drive_t'(clamp_drive(acc >>> FRAC_W));
            last_error = error_t'(err);
            last_drive = r.drive;
        end
        else begin
            dt = c.timestamp - last_stamp;
            if (dt == '0) begin
                r.status = 1'b1;
                r.drive = last_drive;
            end
            else begin
                prod = longint'(kd) * (err - longint'(last_error));
                neg = prod < 0;
                mag = neg ? -prod : prod;
                quot = mag / {32'b0, dt};
                dterm = neg ? -longint'(quot) : longint'(quot);
                r.drive = drive_t'(clamp_drive((acc + dterm) >>> FRAC_W));
                last_error = error_t'(err);
                last_stamp = c.timestamp;
                last_drive = r.drive;
            end
        end
        return r;
    endfunction

    // Command driver.
    always @(posedge clk) begin
        cmd_item_t c;
        if (!rst_n) begin
            cmd_ch.valid <= 1'b0;
        end
        else if (!cmd_ch.valid || cmd_ch.ready) begin
            if (pending_cmds.size() > 0 && $urandom_range(99, 0) >= send_idle_pct) begin
                c = pending_cmds.pop_front();
                cmd_ch.valid     <= 1'b1;
                cmd_ch.func      <= c.func;
                cmd_ch.setpoint  <= c.setpoint;
                cmd_ch.measured  <= c.measured;
                cmd_ch.timestamp <= c.timestamp;
            end
            else begin
                cmd_ch.valid <= 1'b0;
            end
        end
    end

    always @(posedge clk) begin
        rsp_ch.ready <= rst_n && ($urandom_range(99, 0) >= stall_pct);
    end

    // Monitor: predict on each accepted command, check each accepted response.
    always @(posedge clk) begin
        cmd_item_t   c;
        drive_item_t want;
        if (rst_n && cmd_ch.valid && cmd_ch.ready) begin
            c.func      = cmd_ch.func;
            c.setpoint  = cmd_ch.setpoint;
            c.measured  = cmd_ch.measured;
            c.timestamp = cmd_ch.timestamp;
            expected_drives.push_back(compute_drive(c));
        end
        if (rst_n && rsp_ch.valid && rsp_ch.ready) begin
            results_seen++;
            if (expected_drives.size() == 0) begin
                mismatches++;
                if (mismatches <= 10)
                    $display("unexpected response: drive %0d status %0d",
                             rsp_ch.drive, rsp_ch.status);
            end
            else begin
                want = expected_drives.pop_front();
                if (rsp_ch.drive !== want.drive || rsp_ch.status !== want.status) begin
                    mismatches++;
                    if (mismatches <= 10)
                        $display("mismatch: drive exp %0d got %0d, status exp %0d got %0d",
                                 want.drive, rsp_ch.drive, want.status, rsp_ch.status);
                end
            end
        end
    end

    task automatic queue_cmd(logic func, value_t sp, value_t ms, stamp_t ts);
        cmd_item_t c;
        c.func      = func;
        c.setpoint  = sp;
        c.measured  = ms;
        c.timestamp = ts;
        if (func)
            gen_stamp = ts;
        pending_cmds.push_back(c);
        items_queued++;
    endtask

    task automatic wait_until_drained();
        while (results_seen < items_queued)
            @(posedge clk);
    endtask

    task automatic write_gain(reg_idx_t idx, gain_t val);
        @(posedge clk);
        cfg_we    <= 1'b1;
        cfg_idx   <= idx;
        cfg_wdata <= val;
        if (idx == REG_PROP_GAIN)
            kp = val;
        else
            kd = val;
        @(posedge clk);
        cfg_we <= 1'b0;
    endtask

    function automatic value_t pick_value();
        int sel;
        sel = $urandom_range(9, 0);
        if (sel < 5)
            return value_t'(int'($urandom_range(600, 0)) - 300);
        if (sel < 8)
            return value_t'($urandom);
        case ($urandom_range(3, 0))
            0: return value_t'(16'h8000);
            1: return value_t'(16'h7fff);
            2: return value_t'(16'h0000);
            default: return value_t'(16'hffff);
        endcase
    endfunction

    function automatic stamp_t pick_step();
        int sel;
        sel = $urandom_range(9, 0);
        if (sel == 0)
            return '0;
        if (sel < 7)
            return stamp_t'($urandom_range(16, 1));
        if (sel < 9)
            return stamp_t'($urandom_range(1000, 17));
        return stamp_t'($urandom);
    endfunction

    function automatic gain_t pick_gain();
        case ($urandom_range(4, 0))
            0: return gain_t'(16'h8000);
            1: return gain_t'(16'h7fff);
            2: return gain_t'(int'($urandom_range(1024, 0)) - 512);
            default: return gain_t'($urandom);
        endcase
    endfunction

    task automatic run_random_phase(int count, int idle, int stall);
        int burst;
        send_idle_pct = idle;
        stall_pct = stall;
        while (count > 0) begin
            burst = $urandom_range(60, 1);
            if (burst > count)
                burst = count;
            count -= burst;
            repeat (burst) begin
                if ($urandom_range(9, 0) < 7)
                    queue_cmd(1'b1, pick_value(), pick_value(), gen_stamp + pick_step());
                else
                    queue_cmd(1'b0, pick_value(), pick_value(), stamp_t'($urandom));
            end
            if ($urandom_range(3, 0) == 0)
                wait_until_drained();
        end
        wait_until_drained();
    endtask

    initial begin
        rst_n            = 1'b0;
        cfg_we           = 1'b0;
        cfg_idx          = REG_PROP_GAIN;
        cfg_wdata        = '0;
        cmd_ch.valid     = 1'b0;
        cmd_ch.func      = 1'b0;
        cmd_ch.setpoint  = '0;
        cmd_ch.measured  = '0;
        cmd_ch.timestamp = '0;
        rsp_ch.ready     = 1'b0;
        kp               = PROP_GAIN_RESET;
        kd               = DERIV_GAIN_RESET;
        last_error       = '0;
        last_stamp       = '0;
        last_drive       = '0;
        gen_stamp        = '0;
        send_idle_pct    = 0;
        stall_pct        = 0;
        items_queued     = 0;
        results_seen     = 0;
        mismatches       = 0;
        repeat (11) @(posedge clk);
        rst_n <= 1'b1;

        queue_cmd(1'b1, 16'sd0, 16'sd0, 32'h0000_0000);
        queue_cmd(1'b0, 16'sd100, -16'sd50, 32'h1234_5678);
        queue_cmd(1'b1, 16'sh7fff, 16'sh8000, 32'h0000_0000);
        queue_cmd(1'b1, 16'sh7fff, 16'sh8000, 32'h0000_0001);
        queue_cmd(1'b0, 16'sh8000, 16'sh7fff, 32'hffff_ffff);
        wait_until_drained();

        write_gain(REG_PROP_GAIN, gain_t'(16'h8000));
        write_gain(REG_DERIV_GAIN, gain_t'(16'h7fff));
        queue_cmd(1'b1, 16'sh8000, 16'sh7fff, 32'hffff_ffff);
        queue_cmd(1'b1, 16'sh7fff, 16'sh8000, 32'h0000_0000);
        queue_cmd(1'b1, 16'sd0, 16'sd1, 32'h0000_0005);
        queue_cmd(1'b1, 16'sd0, 16'sd1, 32'h0000_0005);
        queue_cmd(1'b0, 16'sd1, 16'sd0, 32'h0000_0000);
        queue_cmd(1'b1, 16'sd3, 16'sd0, 32'h0000_0008);
        wait_until_drained();

        write_gain(REG_PROP_GAIN, gain_t'(16'h7fff));
        write_gain(REG_DERIV_GAIN, gain_t'(16'h8000));
        queue_cmd(1'b1, 16'sh7fff, 16'sh8000, 32'h0000_0009);
        queue_cmd(1'b1, 16'sh8000, 16'sh7fff, 32'h0000_000a);
        queue_cmd(1'b0, -16'sd1, 16'sd0, 32'h5555_aaaa);
        queue_cmd(1'b1, 16'sd12345, -16'sd4321, 32'h8000_0000);
        queue_cmd(1'b1, -16'sd7, 16'sd9, 32'h8000_0003);
        wait_until_drained();

        write_gain(REG_PROP_GAIN, pick_gain());
        write_gain(REG_DERIV_GAIN, pick_gain());
        run_random_phase(250, 0, 0);

        write_gain(REG_PROP_GAIN, gain_t'(16'h7fff));
        write_gain(REG_DERIV_GAIN, gain_t'(16'h7fff));
        run_random_phase(250, 60, 0);

        write_gain(REG_PROP_GAIN, gain_t'(16'h8000));
        write_gain(REG_DERIV_GAIN, gain_t'(16'h8000));
        run_random_phase(250, 0, 60);

        write_gain(REG_PROP_GAIN, pick_gain());
        write_gain(REG_DERIV_GAIN, pick_gain());
        run_random_phase(250, 7, 7);

        write_gain(REG_PROP_GAIN, gain_t'(16'h0000));
        write_gain(REG_DERIV_GAIN, pick_gain());
        run_random_phase(250, 30, 30);

        repeat (60) @(posedge clk);
        if (mismatches == 0 && expected_drives.size() == 0)
            $display("PASS");
        else
            $display("FAIL");
        $finish;
    end

    initial begin
        #(12 * 600000);
        $display("FAIL");
        $finish;
    end

endmodule

/* sim.f */
+incdir+rtl
rtl/pdc_pkg.sv
rtl/pdc_cmd_if.sv
rtl/pd_controller_step.sv
bench/tb_top.sv
